FILE: rtl/core/perceptron_branch_predictor_defines.svh
// Assertion macros for the perceptron branch predictor.
// PBP_ASSERT_SAME checks a consequent in the same cycle as its antecedent.
// PBP_ASSERT_NEXT checks a consequent in the cycle after its antecedent.
`ifndef PERCEPTRON_BRANCH_PREDICTOR_DEFINES_SVH
`define PERCEPTRON_BRANCH_PREDICTOR_DEFINES_SVH

`ifndef SYNTHESIS
`define PBP_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PBP_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define PBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/core/pbp_pkg.sv
package pbp_pkg;

    // Sequencer states, one-hot.
    typedef enum logic [4:0]
    {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_READ  = 5'b00100,
        ST_SUM   = 5'b01000,
        ST_FINAL = 5'b10000
    } pbp_state_t;

    // Transaction kinds carried on the input tuser bit.
    localparam logic ACT_PREDICT = 1'b0;
    localparam logic ACT_UPDATE  = 1'b1;

    localparam int SCORE_BITS = 13;
    localparam int SCORE_MAX  = 4095;
    localparam int SCORE_MIN  = -4096;

    localparam int THRESH_BITS = 12;
    localparam logic [THRESH_BITS-1:0] THRESH_RESET = 12'd4095;

    localparam int PC_BITS    = 64;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 16;

    // Weights are summed in registered groups of this many slots.
    localparam int GROUP_SIZE = 8;
    localparam int GROUP_LOG  = 3;

endpackage

FILE: rtl/core/perceptron_branch_predictor.sv
// Global-history perceptron branch predictor.
// Input channel s_*: one transaction per branch event. s_tuser is the kind
// (0 predict, 1 update); s_tdata carries pc and the resolved direction.
// Output channel m_*: exactly one result transaction per input transaction,
// in order, carrying the prediction, the score and the trained flag.
// Configuration: cfg_we writes cfg_wdata into the training threshold.
// Each transaction is handled by a four-step sequencer around the weight
// memory: accept, row read, group sums plus trained row, final sum and
// write back. The result is registered in the final step, and the next
// transaction is taken only once the sequencer is back at its accept step,
// so a new transaction waits until the previous one has finished.
// The block accepts a new transaction while a finished result still waits
// in the output register; if the receiver stalls, the sequencer holds in its
// last step until that register frees, and s_tready stays low meanwhile.
// After reset the weight memory is cleared one row per cycle, all
// 2**INDEX_BITS rows (1024 by default); s_tready is low meanwhile, while
// configuration writes are taken at once. Reset also empties the history,
// zeroes the kept score and sets the threshold to 4095.
module perceptron_branch_predictor #(
    parameter int HISTORY_LENGTH = 24,
    parameter int INDEX_BITS     = 10,
    parameter int WEIGHT_BITS    = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // s_tdata fields from bit 0: pc[63:0], outcome_taken[64], zero padding.
    input  logic [pbp_pkg::IN_TDATA_W-1:0]     s_tdata,
    // s_tuser fields from bit 0: action.
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tdata fields from bit 0: predicted_taken[0], score[13:1],
    // trained[14], zero padding.
    output logic [pbp_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                               cfg_we,
    input  logic [pbp_pkg::THRESH_BITS-1:0]    cfg_wdata
);

`include "perceptron_branch_predictor_defines.svh"

    localparam int H      = HISTORY_LENGTH;
    localparam int W      = WEIGHT_BITS;
    localparam int ROWS   = 1 << INDEX_BITS;
    localparam int ROW_W  = H * W;
    localparam int NG     = (H + pbp_pkg::GROUP_SIZE - 1) / pbp_pkg::GROUP_SIZE;
    localparam int PAD_N  = NG * pbp_pkg::GROUP_SIZE;
    localparam int PART_W = W + 1 + pbp_pkg::GROUP_LOG;
    localparam int SUM_W  = PART_W + pbp_pkg::GROUP_LOG;
    localparam int EXT_W  = SUM_W + pbp_pkg::SCORE_BITS;

    localparam logic signed [W-1:0] W_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] W_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [EXT_W-1:0] SAT_HI = EXT_W'(pbp_pkg::SCORE_MAX);
    localparam logic signed [EXT_W-1:0] SAT_LO = EXT_W'(pbp_pkg::SCORE_MIN);

    // Weight memory, one row of H weights per entry.
    logic [ROW_W-1:0] mem [ROWS];
    logic [ROW_W-1:0] rd_data_reg;
    logic             mem_re;
    logic             mem_we;
    logic [INDEX_BITS-1:0] mem_waddr;
    logic [ROW_W-1:0]      mem_wdata;

    pbp_pkg::pbp_state_t state_reg, state_next;
    logic [INDEX_BITS-1:0] clr_addr_reg;

    // History: fill marks slots that hold a direction, neg marks not taken.
    // Slot 0 is the bias and always reads as +1.
    logic [H-1:0] fill_reg;
    logic [H-1:0] neg_reg;

    logic signed [pbp_pkg::SCORE_BITS-1:0] kept_score_reg;
    logic [pbp_pkg::THRESH_BITS-1:0]       threshold_reg;

    // Per-transaction payload.
    logic                  action_reg;
    logic                  taken_reg;
    logic [INDEX_BITS-1:0] idx_reg;
    logic [INDEX_BITS-1:0] idx_next;
    logic [H-1:0]          hash_word;

    logic signed [PART_W-1:0] part_reg [NG];
    logic signed [PART_W-1:0] part_next [NG];
    logic [ROW_W-1:0]         new_row_reg;
    logic [ROW_W-1:0]         new_row_next;
    logic                     train_reg;
    logic                     train_next;

    logic signed [W:0]         term [PAD_N];
    logic [PAD_N*W-1:0]        row_pad;
    logic [PAD_N-1:0]          fill_pad;
    logic [PAD_N-1:0]          neg_pad;

    logic signed [SUM_W-1:0]               total;
    logic signed [EXT_W-1:0]               total_ext;
    logic signed [pbp_pkg::SCORE_BITS-1:0] score_sat;
    logic [pbp_pkg::SCORE_BITS:0]          kept_mag;

    logic out_valid_reg;
    logic [pbp_pkg::OUT_TDATA_W-1:0] out_data_reg;
    logic in_accept;
    logic finish;

    assign s_tready  = (state_reg == pbp_pkg::ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // The final step may load the output register only once it is free.
    assign finish = (state_reg == pbp_pkg::ST_FINAL) && (!out_valid_reg || m_tready);

    // Row index: low pc bits XOR the history hash word.
    assign hash_word = ~neg_reg;
    assign idx_next  = s_tdata[INDEX_BITS-1:0] ^ INDEX_BITS'(hash_word);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pbp_pkg::ST_CLEAR:
            begin
                if (&clr_addr_reg)
                begin
                    state_next = pbp_pkg::ST_IDLE;
                end
            end
            pbp_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = pbp_pkg::ST_READ;
                end
            end
            pbp_pkg::ST_READ:  state_next = pbp_pkg::ST_SUM;
            pbp_pkg::ST_SUM:   state_next = pbp_pkg::ST_FINAL;
            pbp_pkg::ST_FINAL:
            begin
                if (finish)
                begin
                    state_next = pbp_pkg::ST_IDLE;
                end
            end
            default: state_next = pbp_pkg::ST_CLEAR;
        endcase
    end

    assign mem_re    = (state_reg == pbp_pkg::ST_READ);
    assign mem_we    = (state_reg == pbp_pkg::ST_CLEAR)
                       || (finish && (action_reg == pbp_pkg::ACT_UPDATE) && train_reg);
    assign mem_waddr = (state_reg == pbp_pkg::ST_CLEAR) ? clr_addr_reg : idx_reg;
    assign mem_wdata = (state_reg == pbp_pkg::ST_CLEAR) ? '0 : new_row_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    // Signed terms weight times history sign, padded to whole groups.
    assign row_pad  = (PAD_N*W)'(rd_data_reg);
    assign fill_pad = PAD_N'(fill_reg);
    assign neg_pad  = PAD_N'(neg_reg);

    always_comb
    begin
        logic signed [W:0] wx;
        for (int j = 0; j < PAD_N; j++)
        begin
            wx = (W+1)'($signed(row_pad[j*W +: W]));
            if (!fill_pad[j])
            begin
                term[j] = '0;
            end
            else if (neg_pad[j])
            begin
                term[j] = -wx;
            end
            else
            begin
                term[j] = wx;
            end
        end
    end

    always_comb
    begin
        logic signed [PART_W-1:0] acc;
        for (int g = 0; g < NG; g++)
        begin
            acc = '0;
            for (int k = 0; k < pbp_pkg::GROUP_SIZE; k++)
            begin
                acc = acc + PART_W'(term[g*pbp_pkg::GROUP_SIZE + k]);
            end
            part_next[g] = acc;
        end
    end

    // Trained row: each weight moves by outcome times history sign, saturating.
    always_comb
    begin
        logic signed [W-1:0] wv;
        logic                agree;
        for (int j = 0; j < H; j++)
        begin
            wv    = $signed(rd_data_reg[j*W +: W]);
            agree = neg_reg[j] ^ taken_reg;
            if (fill_reg[j] && agree && (wv != W_MAX))
            begin
                new_row_next[j*W +: W] = wv + W'(1);
            end
            else if (fill_reg[j] && !agree && (wv != W_MIN))
            begin
                new_row_next[j*W +: W] = wv - W'(1);
            end
            else
            begin
                new_row_next[j*W +: W] = wv;
            end
        end
    end

    // Train when the kept direction is wrong or its margin is small.
    assign kept_mag   = kept_score_reg[pbp_pkg::SCORE_BITS-1]
                        ? (pbp_pkg::SCORE_BITS+1)'(-(pbp_pkg::SCORE_BITS+1)'(kept_score_reg))
                        : (pbp_pkg::SCORE_BITS+1)'(kept_score_reg);
    assign train_next = ((!kept_score_reg[pbp_pkg::SCORE_BITS-1]) != taken_reg)
                        || (kept_mag <= (pbp_pkg::SCORE_BITS+1)'(threshold_reg));

    always_comb
    begin
        total = '0;
        for (int g = 0; g < NG; g++)
        begin
            total = total + SUM_W'(part_reg[g]);
        end
    end

    assign total_ext = EXT_W'(total);

    always_comb
    begin
        if (total_ext > SAT_HI)
        begin
            score_sat = pbp_pkg::SCORE_BITS'(pbp_pkg::SCORE_MAX);
        end
        else if (total_ext < SAT_LO)
        begin
            score_sat = pbp_pkg::SCORE_BITS'(pbp_pkg::SCORE_MIN);
        end
        else
        begin
            score_sat = total_ext[pbp_pkg::SCORE_BITS-1:0];
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            action_reg <= s_tuser;
            taken_reg  <= s_tdata[pbp_pkg::PC_BITS];
            idx_reg    <= idx_next;
        end
        if (state_reg == pbp_pkg::ST_SUM)
        begin
            part_reg    <= part_next;
            new_row_reg <= new_row_next;
            train_reg   <= train_next;
        end
        if (finish)
        begin
            if (action_reg == pbp_pkg::ACT_UPDATE)
            begin
                out_data_reg <= {1'b0, train_reg, kept_score_reg,
                                 !kept_score_reg[pbp_pkg::SCORE_BITS-1]};
            end
            else
            begin
                out_data_reg <= {1'b0, 1'b0, score_sat,
                                 !score_sat[pbp_pkg::SCORE_BITS-1]};
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pbp_pkg::ST_CLEAR;
            clr_addr_reg   <= '0;
            fill_reg       <= H'(1);
            neg_reg        <= '0;
            kept_score_reg <= '0;
            threshold_reg  <= pbp_pkg::THRESH_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == pbp_pkg::ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + INDEX_BITS'(1);
            end
            if (cfg_we)
            begin
                threshold_reg <= cfg_wdata;
            end
            if (finish)
            begin
                out_valid_reg <= 1'b1;
                if (action_reg == pbp_pkg::ACT_UPDATE)
                begin
                    fill_reg <= {fill_reg[H-2:1], 2'b11};
                    neg_reg  <= {neg_reg[H-2:1], !taken_reg, 1'b0};
                end
                else
                begin
                    kept_score_reg <= score_sat;
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    `PBP_ASSERT_NEXT(a_accept_reads, clk, rst_n, in_accept, state_reg == pbp_pkg::ST_READ)
    `PBP_ASSERT_SAME(a_bias_slot, clk, rst_n, 1'b1, fill_reg[0] && !neg_reg[0])
    `PBP_ASSERT_SAME(a_result_from_final, clk, rst_n, $rose(out_valid_reg), $past(state_reg == pbp_pkg::ST_FINAL))
    `PBP_ASSERT_SAME(a_no_write_on_read, clk, rst_n, mem_we, !mem_re)

endmodule
